/* design/gn2d_pkg.sv */
package gn2d_pkg;

   localparam int INNER_BITS = 30;

   localparam logic [31:0] HASH_M1 = 32'd3284157443;
   localparam logic [31:0] HASH_M2 = 32'd1911520717;
   localparam logic [31:0] HASH_M3 = 32'd2048419325;

   // 2/pi in Q0.64, truncated
   localparam logic [63:0] TWO_OVER_PI = 64'hA2F9_836E_4E44_1529;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [33:0] FADE_15 = 34'd15 << INNER_BITS;
   localparam logic [33:0] FADE_10 = 34'd10 << INNER_BITS;

   localparam logic [31:0] SCALE_RESET = 32'h4000_0000;
   localparam logic        REG_SCALE   = 1'b0;

   typedef logic [31:0] coef_arr_type [7];
   // sin(pi/2 t) Taylor coefficients in Q30: c1, c3, ... c13
   localparam coef_arr_type SINE_COEF = '{
      32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
      32'd172272, 32'd3864, 32'd61
   };

   typedef struct packed {
      logic [29:0] fx;
      logic [29:0] fy;
   } frac_type;

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
   } fade_type;

   typedef struct packed {
      logic [1:0]  quad;
      logic [30:0] t_s;
      logic [30:0] t_c;
      logic [30:0] u_s;
      logic [30:0] u_c;
      logic [31:0] p_s;
      logic [31:0] p_c;
   } sine_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] m1;
      logic [63:0] m2;
      logic [63:0] hi;
   } phase_part_type;

   function automatic logic [31:0] rot16(logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

endpackage

/* design/gradient_noise_2d.sv */
// 2D gradient noise, one sample point per clock while rsp is not stalled. A
// point enters on the req beat and its noise value leaves on the rsp beat;
// the pipeline stages are 24 registers deep, with the four lattice corners
// handled in parallel lanes. Every stage advances together whenever the
// output register is empty or being taken, so a stalled rsp holds the
// whole pipe. The angle scale register (Q2.30) is written over the APB port
// at address 0 and must only change while no sample is in flight.
module gradient_noise_2d import gn2d_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_sample_x,
   input  logic signed [31:0] req_sample_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_noise_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int NST = 24;
   localparam int OUT_SHIFT = INNER_BITS - FRACTION_BITS;

   logic adv;
   logic csr_wr;
   logic [NST-1:0] vld_ff;
   logic [31:0] scale_ff;

   // stage payload registers
   logic [31:0] cx_ff [2];
   logic [31:0] cy_ff [2];
   logic [31:0] cy2_ff [2];
   frac_type    frac_ff [15];
   logic [29:0] w2x_ff, w2y_ff, w3x_ff, w3y_ff;
   logic [33:0] t15x_ff, t15y_ff, wix_ff, wiy_ff;
   fade_type    fade_ff [18];
   logic [31:0] ha_ff [4];
   logic [31:0] ha3_ff [4];
   logic [31:0] hb_ff [4];
   logic [31:0] hash_ff [4];
   logic [63:0] prod_ff [4];
   phase_part_type pp_ff [4];
   logic [31:0] phase_ff [4];
   sine_type    sin_ff [8][4];
   logic signed [63:0] dpx_ff [4];
   logic signed [63:0] dpy_ff [4];
   logic signed [34:0] dot_ff [4];
   logic signed [34:0] d0_ff [2];
   logic signed [35:0] df_ff [2];
   logic signed [34:0] b19_ff [2];
   logic signed [68:0] lp_ff [2];
   logic signed [35:0] row_ff [2];
   logic signed [35:0] r0_ff, r0b_ff;
   logic signed [36:0] rd_ff;
   logic signed [69:0] yp_ff;
   logic signed [35:0] fin_ff;
   logic signed [16:0] noise_ff;

   // next values
   logic signed [31:0] ix_in, iy_in;
   frac_type    frac_in;
   logic [59:0] w2x_in, w2y_in, w3x_in, w3y_in;
   logic [63:0] wix_in, wiy_in, sxp_in, syp_in;
   logic [33:0] innx_in, inny_in;
   logic [31:0] ha_in [4];
   logic [31:0] hb_in [4];
   logic [31:0] hash_in [4];
   logic [63:0] prod_in [4];
   phase_part_type pp_in [4];
   logic [63:0] mid_in [4];
   logic [31:0] phase_in [4];
   sine_type    sin_in [8][4];
   logic [61:0] tts_in [4];
   logic [61:0] ttc_in [4];
   logic [62:0] hs_in [7][4];
   logic [62:0] hc_in [7][4];
   logic signed [30:0] dx_in [4];
   logic signed [30:0] dy_in [4];
   logic signed [32:0] s0_in [4];
   logic signed [32:0] c0_in [4];
   logic signed [32:0] gs_in [4];
   logic signed [32:0] gc_in [4];
   logic signed [64:0] dsum_in [4];
   logic signed [35:0] fin_sh_in;

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_noise_value = noise_ff;

   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_SCALE);
   assign prdata = (paddr[2] == REG_SCALE) ? scale_ff : '0;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr) begin
         scale_ff <= pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_comb begin
      // stage 1: lattice corner and fraction
      ix_in = req_sample_x >>> FRACTION_BITS;
      iy_in = req_sample_y >>> FRACTION_BITS;
      frac_in.fx = {req_sample_x[FRACTION_BITS-1:0], {OUT_SHIFT{1'b0}}};
      frac_in.fy = {req_sample_y[FRACTION_BITS-1:0], {OUT_SHIFT{1'b0}}};

      // fade: w^2, w^3, w*(15 - 6w), then w^3 * (10 - ...)
      w2x_in = {30'b0, frac_ff[0].fx} * {30'b0, frac_ff[0].fx};
      w2y_in = {30'b0, frac_ff[0].fy} * {30'b0, frac_ff[0].fy};
      w3x_in = {30'b0, w2x_ff} * {30'b0, frac_ff[1].fx};
      w3y_in = {30'b0, w2y_ff} * {30'b0, frac_ff[1].fy};
      wix_in = {34'b0, frac_ff[1].fx} * {30'b0, t15x_ff};
      wiy_in = {34'b0, frac_ff[1].fy} * {30'b0, t15y_ff};
      innx_in = FADE_10 - wix_ff;
      inny_in = FADE_10 - wiy_ff;
      sxp_in = {34'b0, w3x_ff} * {30'b0, innx_in};
      syp_in = {34'b0, w3y_ff} * {30'b0, inny_in};

      for (int k = 0; k < 4; k++) begin
         ha_in[k]   = cx_ff[k & 1] * HASH_M1;
         hb_in[k]   = (cy2_ff[k >> 1] ^ rot16(ha_ff[k])) * HASH_M2;
         hash_in[k] = (ha3_ff[k] ^ rot16(hb_ff[k])) * HASH_M3;
         prod_in[k] = {32'b0, hash_ff[k]} * {32'b0, scale_ff};

         pp_in[k].lo = {32'b0, prod_ff[k][31:0]}  * {32'b0, TWO_OVER_PI[31:0]};
         pp_in[k].m1 = {32'b0, prod_ff[k][63:32]} * {32'b0, TWO_OVER_PI[31:0]};
         pp_in[k].m2 = {32'b0, prod_ff[k][31:0]}  * {32'b0, TWO_OVER_PI[63:32]};
         pp_in[k].hi = {32'b0, prod_ff[k][63:32]} * {32'b0, TWO_OVER_PI[63:32]};

         mid_in[k] = {32'b0, pp_ff[k].lo[63:32]} + {32'b0, pp_ff[k].m1[31:0]}
                   + {32'b0, pp_ff[k].m2[31:0]};
         phase_in[k] = pp_ff[k].hi[31:0] + pp_ff[k].m1[63:32] + pp_ff[k].m2[63:32]
                     + mid_in[k][63:32];

         // sine entry: quarter position, its square, top coefficient
         sin_in[0][k].quad = phase_ff[k][31:30];
         sin_in[0][k].t_s  = {1'b0, phase_ff[k][29:0]};
         sin_in[0][k].t_c  = ONE_Q30 - {1'b0, phase_ff[k][29:0]};
         tts_in[k] = {31'b0, sin_in[0][k].t_s} * {31'b0, sin_in[0][k].t_s};
         ttc_in[k] = {31'b0, sin_in[0][k].t_c} * {31'b0, sin_in[0][k].t_c};
         sin_in[0][k].u_s = tts_in[k][60:30];
         sin_in[0][k].u_c = ttc_in[k][60:30];
         sin_in[0][k].p_s = SINE_COEF[6];
         sin_in[0][k].p_c = SINE_COEF[6];
         hs_in[0][k] = '0;
         hc_in[0][k] = '0;

         // Horner steps, one per stage
         for (int j = 1; j < 7; j++) begin
            sin_in[j][k] = sin_ff[j-1][k];
            hs_in[j][k] = {32'b0, sin_ff[j-1][k].u_s} * {31'b0, sin_ff[j-1][k].p_s};
            hc_in[j][k] = {32'b0, sin_ff[j-1][k].u_c} * {31'b0, sin_ff[j-1][k].p_c};
            sin_in[j][k].p_s = SINE_COEF[6-j] - hs_in[j][k][61:30];
            sin_in[j][k].p_c = SINE_COEF[6-j] - hc_in[j][k][61:30];
         end

         // final t * p
         sin_in[7][k] = sin_ff[6][k];
         sin_in[7][k].p_s = 32'(({32'b0, sin_ff[6][k].t_s} * {31'b0, sin_ff[6][k].p_s})
                                >> INNER_BITS);
         sin_in[7][k].p_c = 32'(({32'b0, sin_ff[6][k].t_c} * {31'b0, sin_ff[6][k].p_c})
                                >> INNER_BITS);

         // gradient by quadrant, dot with the corner offset
         s0_in[k] = $signed({1'b0, sin_ff[7][k].p_s});
         c0_in[k] = $signed({1'b0, sin_ff[7][k].p_c});
         case (sin_ff[7][k].quad)
            2'd0: begin
               gs_in[k] = s0_in[k];
               gc_in[k] = c0_in[k];
            end
            2'd1: begin
               gs_in[k] = c0_in[k];
               gc_in[k] = -s0_in[k];
            end
            2'd2: begin
               gs_in[k] = -s0_in[k];
               gc_in[k] = -c0_in[k];
            end
            default: begin
               gs_in[k] = -c0_in[k];
               gc_in[k] = s0_in[k];
            end
         endcase
         dx_in[k] = ((k & 1) != 0) ? $signed({1'b0, frac_ff[14].fx} - ONE_Q30)
                                   : $signed({1'b0, frac_ff[14].fx});
         dy_in[k] = ((k >> 1) != 0) ? $signed({1'b0, frac_ff[14].fy} - ONE_Q30)
                                    : $signed({1'b0, frac_ff[14].fy});
         dsum_in[k] = dpx_ff[k] + dpy_ff[k];
      end

      fin_sh_in = fin_ff >>> OUT_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0] <= ix_in;
         cx_ff[1] <= ix_in + 32'd1;
         cy_ff[0] <= iy_in;
         cy_ff[1] <= iy_in + 32'd1;
         cy2_ff   <= cy_ff;
         frac_ff[0] <= frac_in;
         for (int i = 1; i < 15; i++) begin
            frac_ff[i] <= frac_ff[i-1];
         end

         w2x_ff  <= w2x_in[59:30];
         w2y_ff  <= w2y_in[59:30];
         t15x_ff <= FADE_15 - ({4'b0, frac_ff[0].fx} * 34'd6);
         t15y_ff <= FADE_15 - ({4'b0, frac_ff[0].fy} * 34'd6);
         w3x_ff  <= w3x_in[59:30];
         w3y_ff  <= w3y_in[59:30];
         wix_ff  <= wix_in[63:30];
         wiy_ff  <= wiy_in[63:30];
         fade_ff[0].sx <= sxp_in[61:30];
         fade_ff[0].sy <= syp_in[61:30];
         for (int i = 1; i < 18; i++) begin
            fade_ff[i] <= fade_ff[i-1];
         end

         for (int k = 0; k < 4; k++) begin
            ha_ff[k]    <= ha_in[k];
            ha3_ff[k]   <= ha_ff[k];
            hb_ff[k]    <= hb_in[k];
            hash_ff[k]  <= hash_in[k];
            prod_ff[k]  <= prod_in[k];
            pp_ff[k]    <= pp_in[k];
            phase_ff[k] <= phase_in[k];
            for (int j = 0; j < 8; j++) begin
               sin_ff[j][k] <= sin_in[j][k];
            end
            dpx_ff[k] <= dx_in[k] * gc_in[k];
            dpy_ff[k] <= dy_in[k] * gs_in[k];
            dot_ff[k] <= dsum_in[k][64:30];
         end

         // blend in x, then in y
         for (int r = 0; r < 2; r++) begin
            d0_ff[r]  <= dot_ff[2*r];
            df_ff[r]  <= 36'(dot_ff[2*r+1]) - 36'(dot_ff[2*r]);
            b19_ff[r] <= d0_ff[r];
            lp_ff[r]  <= df_ff[r] * $signed({1'b0, fade_ff[14].sx});
            row_ff[r] <= 36'(b19_ff[r]) + lp_ff[r][65:30];
         end
         r0_ff  <= row_ff[0];
         rd_ff  <= 37'(row_ff[1]) - 37'(row_ff[0]);
         r0b_ff <= r0_ff;
         yp_ff  <= rd_ff * $signed({1'b0, fade_ff[17].sy});
         fin_ff <= r0b_ff + yp_ff[65:30];

         if (fin_sh_in > 36'sd65535) begin
            noise_ff <= 17'sh0FFFF;
         end else if (fin_sh_in < -36'sd65536) begin
            noise_ff <= 17'sh10000;
         end else begin
            noise_ff <= fin_sh_in[16:0];
         end
      end
   end

`ifndef SYNTHESIS
   // hold every stage while the output stalls
   assert property (@(posedge clock) disable iff (reset) !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   assert property (@(posedge clock) disable iff (reset)
      (adv && req_valid) |=> vld_ff[0])
      else $error("accepted beat did not enter the first stage");

   assert property (@(posedge clock) disable iff (reset)
      (adv && !req_valid) |=> !vld_ff[0])
      else $error("first stage valid without an accepted beat");

   assert property (@(posedge clock) disable iff (reset)
      !csr_wr |=> $stable(scale_ff))
      else $error("angle scale changed without a register write");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gn2d_pkg::*;

   localparam int FRAC      = 16;
   localparam int LATENCY   = 24;
   localparam int N_RANDOM  = 1400;
   localparam longint LIMIT = 400000;
   localparam logic [2:0] ADDR_SCALE = 3'd0;

   // Q30 sine Taylor coefficients c1..c13
   localparam longint unsigned SIN_C [7] = '{
      64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
      64'd172272, 64'd3864, 64'd61
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_sample_x = '0;
   logic signed [31:0] req_sample_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [16:0] rsp_noise_value;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   int     n_fail = 0;
   longint cycle_count = 0;
   logic [31:0] angle_scale = SCALE_RESET;

   gradient_noise_2d #(.FRACTION_BITS(FRAC)) i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_sample_x, .req_sample_y,
      .rsp_valid, .rsp_ready, .rsp_noise_value,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint fshr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic logic [31:0] hash_corner(logic [31:0] a, logic [31:0] b);
      a = a * 32'd3284157443;
      b = b ^ {a[15:0], a[31:16]};
      b = b * 32'd1911520717;
      a = a ^ {b[15:0], b[31:16]};
      a = a * 32'd2048419325;
      return a;
   endfunction

   function automatic logic [31:0] angle_phase(logic [31:0] h, logic [31:0] sc);
      logic [63:0]  p;
      logic [127:0] full;
      p = 64'(h) * 64'(sc);
      full = 128'(p) * 128'(64'hA2F9_836E_4E44_1529);
      return full[95:64];
   endfunction

   function automatic longint qsine(longint unsigned t);
      longint unsigned u, p;
      u = (t * t) >> 30;
      p = SIN_C[6];
      for (int k = 5; k >= 0; k--) p = SIN_C[k] - ((u * p) >> 30);
      return longint'((t * p) >> 30);
   endfunction

   function automatic longint grad_dot(logic [31:0] cx, logic [31:0] cy,
                                       longint dx, longint dy, logic [31:0] sc);
      logic [31:0] ph;
      longint unsigned t;
      longint s0, c0, gs, gc;
      ph = angle_phase(hash_corner(cx, cy), sc);
      t = {34'd0, ph[29:0]};
      s0 = qsine(t);
      c0 = qsine((64'd1 << 30) - t);
      case (ph[31:30])
         2'd0: begin gs = s0; gc = c0; end
         2'd1: begin gs = c0; gc = -s0; end
         2'd2: begin gs = -s0; gc = -c0; end
         default: begin gs = -c0; gc = s0; end
      endcase
      return fshr(dx * gc + dy * gs, 30);
   endfunction

   function automatic longint quintic(longint unsigned w);
      longint unsigned w2, w3, inner;
      w2 = (w * w) >> 30;
      w3 = (w2 * w) >> 30;
      inner = (64'd10 << 30) - ((w * ((64'd15 << 30) - 64'd6 * w)) >> 30);
      return longint'((w3 * inner) >> 30);
   endfunction

   function automatic longint blend(longint a0, longint a1, longint f);
      return a0 + fshr((a1 - a0) * f, 30);
   endfunction

   function automatic logic [16:0] noise_at(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] sc);
      logic [31:0] cx0, cy0;
      longint fx, fy, sx, sy, r0, r1, v;
      cx0 = 32'($signed(x) >>> FRAC);
      cy0 = 32'($signed(y) >>> FRAC);
      fx = longint'(x[FRAC-1:0]) << (30 - FRAC);
      fy = longint'(y[FRAC-1:0]) << (30 - FRAC);
      sx = quintic(fx);
      sy = quintic(fy);
      r0 = blend(grad_dot(cx0, cy0, fx, fy, sc),
                 grad_dot(cx0 + 1, cy0, fx - (64'sd1 << 30), fy, sc), sx);
      r1 = blend(grad_dot(cx0, cy0 + 1, fx, fy - (64'sd1 << 30), sc),
                 grad_dot(cx0 + 1, cy0 + 1, fx - (64'sd1 << 30),
                          fy - (64'sd1 << 30), sc), sx);
      v = fshr(blend(r0, r1, sy), 30 - FRAC);
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
      return v[16:0];
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      n_fail++;
   endtask

   class noise_scoreboard;
      logic [16:0] pending_noise [$];

      function void note_sample(logic [31:0] x, logic [31:0] y, logic [31:0] sc);
         pending_noise.insert(pending_noise.size(), noise_at(x, y, sc));
      endfunction

      task check_noise(logic [16:0] got);
         logic [16:0] want;
         if (pending_noise.size() == 0) begin
            report_mismatch($sformatf("unexpected noise beat %0d", $signed(got)));
         end else begin
            want = pending_noise.pop_front();
            if (got !== want)
               report_mismatch($sformatf("noise_value got %0d want %0d",
                                         $signed(got), $signed(want)));
         end
      endtask
   endclass

   noise_scoreboard sb = new();

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready)
         sb.note_sample(req_sample_x, req_sample_y, angle_scale);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_noise(rsp_noise_value);
      if (cycle_count > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // random stall on the result side, with stall-free stretches
   initial begin
      int wait_n;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
         wait_n = $urandom_range(0, 5);
         if (wait_n != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   task automatic write_scale(logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_SCALE; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      angle_scale = value;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_pipe();
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_sample(logic [31:0] x, logic [31:0] y, bit burst);
      if (!burst) begin
         int gap;
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_sample_x <= x;
      req_sample_y <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000)) - 1000) << FRAC
                   | 32'($urandom_range(0, 65535));
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         3: return {1'b1, 15'($urandom), 16'($urandom)};
         4: return 32'h7FFF_0000 | 32'($urandom_range(0, 65535));
         default: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
      endcase
   endfunction

   initial begin
      logic [31:0] dx [$];
      logic [31:0] scales [5];
      bit burst;
      dx = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF,
             32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h7FFF_0000,
             32'h8000_FFFF, 32'h0000_0001};
      scales = '{32'h4000_0000, 32'h0, 32'hC000_0000, 32'hFFFF_FFFF, 32'h0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: corners of the coordinate range at reset scale
      foreach (dx[i]) send_sample(dx[i], dx[(i * 3 + 1) % dx.size()], 1'b0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
      end_burst();
      for (int ph = 1; ph < 5; ph++) begin
         drain_pipe();
         scales[4] = $urandom;
         write_scale(scales[ph]);
         for (int k = 0; k < 6; k++) send_sample(dx[k], dx[k + 5], 1'b0);
         for (int n = 0; n < N_RANDOM / 4; n++) begin
            burst = ($urandom_range(0, 3) == 0);
            send_sample(rand_coord(), rand_coord(), burst);
            if (n == 100) begin
               end_burst();
               @(posedge clock);
               while (sb.pending_noise.size() != 0) @(posedge clock);
            end
         end
         end_burst();
      end
      drain_pipe();
      write_scale(SCALE_RESET);
      for (int n = 0; n < 20; n++) send_sample(rand_coord(), rand_coord(), 1'b1);
      end_burst();
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (n_fail == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

/* gradient_noise_2d.f */
design/gn2d_pkg.sv
design/gradient_noise_2d.sv
dv/tb_top.sv
